### sv/sst_pkg.sv
// Shared types and constants for the sorted string table search block.
`timescale 1ns / 1ps

package sst_pkg;

  // Default table geometry
  localparam int unsigned ENTRIES_DEF   = 65536;
  localparam int unsigned KEY_WORDS_DEF = 7;

  // Fixed field widths
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned SEL_W  = 3;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned CFG_W  = 17;

  // Command codes
  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_CNT   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Search sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_CMP  = 3'b100
  } state_e;

  // Write request from the sequencer to the table stores
  typedef struct packed {
    logic              key_we;
    logic              cnt_we;
    logic [IDX_W-1:0]  idx;
    logic [SEL_W-1:0]  sel;
    logic [DATA_W-1:0] data;
  } store_req_t;

endpackage

### sv/sst_store.sv
// Key row memory and count memory, one synchronous read port each.
`timescale 1ns / 1ps

module sst_store import sst_pkg::*; #(
  parameter int unsigned ENTRIES   = ENTRIES_DEF,
  parameter int unsigned KEY_WORDS = KEY_WORDS_DEF,
  localparam int unsigned IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned WselW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1
) (
  input  logic                                 clk_i,
  input  store_req_t                           req_i,
  input  logic                                 rd_en_i,
  input  logic [IdxW-1:0]                      rd_idx_i,
  output logic [0:KEY_WORDS-1][DATA_W-1:0]     rd_key_o,
  output logic [DATA_W-1:0]                    rd_cnt_o
);

  // One row per entry, word 0 is the most significant word of the row
  logic [0:KEY_WORDS-1][DATA_W-1:0] key_mem_q [ENTRIES];
  logic [DATA_W-1:0]                cnt_mem_q [ENTRIES];

  logic [0:KEY_WORDS-1][DATA_W-1:0] rd_key_q;
  logic [DATA_W-1:0]                rd_cnt_q;
  logic [IdxW-1:0]                  wr_addr;
  logic [WselW-1:0]                 wr_word;

  assign wr_addr = IdxW'(req_i.idx);
  assign wr_word = WselW'(req_i.sel);

  // Key memory: word-enable write, registered row read
  always_ff @(posedge clk_i) begin
    if (req_i.key_we) begin
      key_mem_q[wr_addr][wr_word] <= req_i.data;
    end
    if (rd_en_i) begin
      rd_key_q <= key_mem_q[rd_idx_i];
    end
  end

  // Count memory, read alongside the key row
  always_ff @(posedge clk_i) begin
    if (req_i.cnt_we) begin
      cnt_mem_q[wr_addr] <= req_i.data;
    end
    if (rd_en_i) begin
      rd_cnt_q <= cnt_mem_q[rd_idx_i];
    end
  end

  assign rd_key_o = rd_key_q;
  assign rd_cnt_o = rd_cnt_q;

endmodule

### sv/sst_search.sv
// Command decode, query key register and binary search sequencer.
`timescale 1ns / 1ps

module sst_search import sst_pkg::*; #(
  parameter int unsigned ENTRIES   = ENTRIES_DEF,
  parameter int unsigned KEY_WORDS = KEY_WORDS_DEF,
  localparam int unsigned IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CntW  = $clog2(ENTRIES + 1),
  localparam int unsigned WselW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        cmd_i,
  input  logic [IDX_W-1:0]                  entry_index_i,
  input  logic [SEL_W-1:0]                  word_sel_i,
  input  logic [DATA_W-1:0]                 data_i,
  input  logic                              last_i,
  input  logic                              cfg_valid_i,
  input  logic [CFG_W-1:0]                  cfg_data_i,
  output store_req_t                        req_o,
  output logic                              rd_en_o,
  output logic [IdxW-1:0]                   rd_idx_o,
  input  logic [0:KEY_WORDS-1][DATA_W-1:0]  rd_key_i,
  input  logic [DATA_W-1:0]                 rd_cnt_i,
  output logic                              valid_o,
  output logic                              found_o,
  output logic [IDX_W-1:0]                  position_o,
  output logic [DATA_W-1:0]                 count_o
);

  state_e state_q, state_d;
  cmd_e   cmd;

  logic [CFG_W-1:0]                 entry_count_q;
  logic [0:KEY_WORDS-1][DATA_W-1:0] qkey_q;
  logic [CntW-1:0]                  lo_q, lo_d, hi_q, hi_d, mid_q, mid_nxt, n_sat;
  logic [CntW:0]                    mid_sum;
  logic                             accept, query_go, idx_ok, sel_ok;
  logic                             finish, hit, key_eq, key_gt;
  logic                             valid_q, found_q;
  logic [IDX_W-1:0]                 pos_q;
  logic [DATA_W-1:0]                cnt_q;

  assign cmd      = cmd_e'(cmd_i);
  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign query_go = accept && (cmd == CMD_QUERY) && last_i;
  assign idx_ok   = 32'(entry_index_i) < ENTRIES;
  assign sel_ok   = 32'(word_sel_i) < KEY_WORDS;

  // Table writes go straight to the stores
  assign req_o.key_we = accept && (cmd == CMD_KEY) && idx_ok && sel_ok;
  assign req_o.cnt_we = accept && (cmd == CMD_CNT) && idx_ok;
  assign req_o.idx    = entry_index_i;
  assign req_o.sel    = word_sel_i;
  assign req_o.data   = data_i;

  // Searched range, saturated to the table depth
  assign n_sat = (32'(entry_count_q) > ENTRIES) ? CntW'(ENTRIES) : CntW'(entry_count_q);

  // Probe index for the current interval
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_nxt  = mid_sum[CntW:1];
  assign rd_en_o  = (state_q == ST_READ);
  assign rd_idx_o = IdxW'(mid_nxt);

  // Full-key compare against the registered row
  assign key_eq = (rd_key_i == qkey_q);
  assign key_gt = (rd_key_i > qkey_q);

  // Sequencer: read a row, then compare and narrow
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    finish  = 1'b0;
    hit     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (query_go) begin
          if (n_sat == '0) begin
            finish = 1'b1;
          end else begin
            lo_d    = '0;
            hi_d    = n_sat;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (key_eq) begin
          finish  = 1'b1;
          hit     = 1'b1;
          state_d = ST_IDLE;
        end else if (mid_q == lo_q) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          if (key_gt) begin
            lo_d = mid_q;
          end else begin
            hi_d = mid_q;
          end
          state_d = ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state, config register and query key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      valid_q       <= 1'b0;
      entry_count_q <= '0;
      qkey_q        <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= finish;
      if (cfg_valid_i) begin
        entry_count_q <= cfg_data_i;
      end
      // a finished search leaves the key zeroed for the next query
      if (finish) begin
        qkey_q <= '0;
      end else if (accept && (cmd == CMD_QUERY) && sel_ok) begin
        qkey_q[WselW'(word_sel_i)] <= data_i;
      end
    end
  end

  // Interval bounds and result word
  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (state_q == ST_READ) begin
      mid_q <= mid_nxt;
    end
    if (finish) begin
      found_q <= hit;
      pos_q   <= hit ? IDX_W'(mid_q) : '0;
      cnt_q   <= hit ? rd_cnt_i : '0;
    end
  end

  assign valid_o    = valid_q;
  assign found_o    = found_q;
  assign position_o = pos_q;
  assign count_o    = cnt_q;

endmodule

### sv/sorted_string_table_search.sv
// Top level: descending key table with binary search lookup.
// Table writes go straight to the stores; busy stays low.
// A query word with last set starts a search of halving steps (row read, then compare),
// up to ceil(log2(n))+1 steps for n entries.
// The result strobe is registered after the final compare, or after the start for an empty table.
// The key and count memories share one read address and set the step time.
// Reset clears the sequencer, entry_count and the query key; table memories are not cleared.
`timescale 1ns / 1ps

module sorted_string_table_search import sst_pkg::*; #(
  parameter int unsigned ENTRIES   = ENTRIES_DEF,
  parameter int unsigned KEY_WORDS = KEY_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        cmd_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [SEL_W-1:0]  word_sel_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              last_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output logic              valid_o,
  output logic              found_o,
  output logic [IDX_W-1:0]  position_o,
  output logic [DATA_W-1:0] count_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  store_req_t                       req;
  logic                             rd_en;
  logic [IdxW-1:0]                  rd_idx;
  logic [0:KEY_WORDS-1][DATA_W-1:0] rd_key;
  logic [DATA_W-1:0]                rd_cnt;

  // config word is always taken
  assign cfg_ready_o = 1'b1;

  sst_search #(
    .ENTRIES   (ENTRIES),
    .KEY_WORDS (KEY_WORDS)
  ) u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .word_sel_i    (word_sel_i),
    .data_i        (data_i),
    .last_i        (last_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .req_o         (req),
    .rd_en_o       (rd_en),
    .rd_idx_o      (rd_idx),
    .rd_key_i      (rd_key),
    .rd_cnt_i      (rd_cnt),
    .valid_o       (valid_o),
    .found_o       (found_o),
    .position_o    (position_o),
    .count_o       (count_o)
  );

  sst_store #(
    .ENTRIES   (ENTRIES),
    .KEY_WORDS (KEY_WORDS)
  ) u_store (
    .clk_i    (clk_i),
    .req_i    (req),
    .rd_en_i  (rd_en),
    .rd_idx_i (rd_idx),
    .rd_key_o (rd_key),
    .rd_cnt_o (rd_cnt)
  );

endmodule

### sv/sst_checker.sv
// Port-level checks for the table search block, bound to the top level.
`timescale 1ns / 1ps

module sst_checker import sst_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              valid_o,
  input logic              found_o,
  input logic [IDX_W-1:0]  position_o,
  input logic [DATA_W-1:0] count_o
);

  // a result is only shown once the search has released the block
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while busy");

  // a miss reports zero index and count
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !found_o) |-> (position_o == '0 && count_o == '0))
    else $error("miss with nonzero position or count");

  // busy only rises after a start
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // a search always ends with a result
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o)
    else $error("search ended without result");

  // every result follows a search or an empty-table query
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(start) || $past(busy)))
    else $error("result without a query");

endmodule

bind sorted_string_table_search sst_checker u_sst_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .valid_o    (valid_o),
  .found_o    (found_o),
  .position_o (position_o),
  .count_o    (count_o)
);

### tb/tb_top.sv
// Self-checking bench for the sorted string table search block.
`timescale 1ns / 1ps

module tb_top;
  import sst_pkg::*;

  localparam int ROWS  = ENTRIES_DEF;
  localparam int WORDS = KEY_WORDS_DEF;
  localparam bit [SEL_W-1:0] SEL_UNUSED = SEL_W'(WORDS);  // first word number past the key

  // Whole key, word 0 in the top bits, so plain unsigned compare orders keys
  typedef bit [WORDS*DATA_W-1:0] key_t;

  typedef struct packed {
    bit              found;
    bit [IDX_W-1:0]  position;
    bit [DATA_W-1:0] count;
  } lookup_t;

  // Mirror of the table plus the queue of lookups still owed by the block
  class lookup_scoreboard;
    bit [DATA_W-1:0] row_words [ROWS*WORDS];
    bit [DATA_W-1:0] row_counts [ROWS];
    bit [DATA_W-1:0] probe [WORDS];
    int              table_size;
    lookup_t         pending [$];
    int              checked;
    int              hits;
    int              errors;

    function key_t row_key(int e);
      key_t k;
      for (int w = 0; w < WORDS; w++) k[(WORDS-1-w)*DATA_W +: DATA_W] = row_words[e*WORDS + w];
      return k;
    endfunction

    // >0 when row e sorts above the probe, 0 when equal, <0 when below
    function int compare_row(int e);
      for (int w = 0; w < WORDS; w++) begin
        if (row_words[e*WORDS + w] > probe[w]) return 1;
        if (row_words[e*WORDS + w] < probe[w]) return -1;
      end
      return 0;
    endfunction

    // Half-open binary search over the descending rows
    function lookup_t search_rows();
      lookup_t r;
      int lo, hi, mid, rel;
      bit done;
      r = '0;
      lo = 0;
      hi = (table_size > ROWS) ? ROWS : table_size;
      done = (hi <= lo);
      while (!done) begin
        mid = (lo + hi) / 2;
        rel = compare_row(mid);
        if (rel == 0) begin
          r.found = 1'b1;
          r.position = IDX_W'(mid);
          r.count = row_counts[mid];
          done = 1'b1;
        end else if (mid <= lo) begin
          done = 1'b1;
        end else if (rel > 0) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      return r;
    endfunction

    function void note_item(cmd_e c, bit [IDX_W-1:0] idx, bit [SEL_W-1:0] sel,
                            bit [DATA_W-1:0] d, bit lst);
      lookup_t r;
      case (c)
        CMD_KEY: if (idx < ROWS && sel < WORDS) row_words[int'(idx)*WORDS + int'(sel)] = d;
        CMD_CNT: if (idx < ROWS) row_counts[idx] = d;
        CMD_QUERY: begin
          if (sel < WORDS) probe[sel] = d;
          if (lst) begin
            r = search_rows();
            pending.push_back(r);
            if (r.found) hits++;
            // probe clears after every search
            foreach (probe[w]) probe[w] = '0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(bit f, bit [IDX_W-1:0] p, bit [DATA_W-1:0] c);
      lookup_t want;
      if (pending.size() == 0) begin
        $error("lookup result with none outstanding: found=%0d position=%0d count=%h", f, p, c);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (f != want.found) begin
        $error("found: expected %0d, got %0d", want.found, f);
        errors++;
      end
      if (p != want.position) begin
        $error("position: expected %0d, got %0d", want.position, p);
        errors++;
      end
      if (c != want.count) begin
        $error("count: expected %h, got %h", want.count, c);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        cmd_i;
  logic [IDX_W-1:0]  entry_index_i;
  logic [SEL_W-1:0]  word_sel_i;
  logic [DATA_W-1:0] data_i;
  logic              last_i;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_data_i;
  logic              valid_o;
  logic              found_o;
  logic [IDX_W-1:0]  position_o;
  logic [DATA_W-1:0] count_o;

  lookup_scoreboard sb;
  bit gaps_on = 1'b1;
  int query_words = 0;
  int items = 0;
  int settings = 0;
  int filled = 0;        // entries 0..filled-1 hold a full key and count
  bit wrote [int];       // deep entries written along probe paths

  sorted_string_table_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .word_sel_i    (word_sel_i),
    .data_i        (data_i),
    .last_i        (last_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .valid_o       (valid_o),
    .found_o       (found_o),
    .position_o    (position_o),
    .count_o       (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #1ms;
    $display("FAIL sorted_string_table_search");
    $finish;
  end

  // Result strobe is one cycle wide, sample it at the closing edge
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(found_o, position_o, count_o);
  end

  function automatic bit [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [DATA_W-1:0] word_of(key_t k, int w);
    return k[(WORDS-1-w)*DATA_W +: DATA_W];
  endfunction

  // Short-string style keys: a few leading words, zero padded
  function automatic key_t random_key();
    key_t k;
    int len;
    k = '0;
    len = $urandom_range(WORDS, 1);
    for (int w = 0; w < len; w++) begin
      case ($urandom_range(3))
        0: k[(WORDS-1-w)*DATA_W +: DATA_W] = rand64();
        1: k[(WORDS-1-w)*DATA_W +: DATA_W] = {8'h61 + 8'($urandom_range(2)), 8'h62, 48'h0};
        2: k[(WORDS-1-w)*DATA_W +: DATA_W] = '1;
        default: k[(WORDS-1-w)*DATA_W +: DATA_W] = 64'h6162_6300_0000_0000;
      endcase
    end
    return k;
  endfunction

  // One command word; start stays up until busy is low at an edge
  task automatic send_item(cmd_e c, bit [IDX_W-1:0] idx, bit [SEL_W-1:0] sel,
                           bit [DATA_W-1:0] d, bit lst);
    while (gaps_on && $urandom_range(99) < 31) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    entry_index_i <= idx;
    word_sel_i <= sel;
    data_i <= d;
    last_i <= lst;
    do @(posedge clk_i); while (busy);
    sb.note_item(c, idx, sel, d, lst);
    items++;
  endtask

  task automatic send_word(bit [SEL_W-1:0] sel, bit [DATA_W-1:0] d, bit lst);
    send_item(CMD_QUERY, IDX_W'($urandom), sel, d, lst);
    query_words++;
  endtask

  // Query words in random order, zero words often left out
  task automatic send_query(key_t k);
    bit [SEL_W-1:0] order [$];
    bit [SEL_W-1:0] t;
    int i, j;
    bit tail;
    for (i = 0; i < WORDS; i++)
      if (word_of(k, i) != '0 || $urandom_range(1) == 1) order.push_back(SEL_W'(i));
    for (i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    // stale value on a word that is sent again below
    if (order.size() != 0 && $urandom_range(4) == 0)
      send_word(order[$urandom_range(order.size() - 1)], rand64(), 1'b0);
    tail = (order.size() == 0) || ($urandom_range(9) == 0);
    for (i = 0; i < order.size(); i++)
      send_word(order[i], word_of(k, order[i]), !tail && (i == order.size() - 1));
    // out-of-range word: stores nothing but still ends the query
    if (tail) send_word(SEL_UNUSED, rand64(), 1'b1);
  endtask

  // Rows go to entries 0.. in the given order, count after the key
  task automatic load_rows(key_t rows [$]);
    bit [DATA_W-1:0] cnt;
    for (int e = 0; e < rows.size(); e++) begin
      for (int w = 0; w < WORDS; w++)
        send_item(CMD_KEY, IDX_W'(e), SEL_W'(w), word_of(rows[e], w), 1'($urandom));
      case ($urandom_range(3))
        0: cnt = '0;
        1: cnt = '1;
        default: cnt = rand64();
      endcase
      send_item(CMD_CNT, IDX_W'(e), SEL_W'($urandom), cnt, 1'($urandom));
    end
    if (rows.size() > filled) filled = rows.size();
  endtask

  // Deep entry: tag in the top 16 bits keeps the full-depth table descending
  task automatic write_tagged(int e);
    send_item(CMD_KEY, IDX_W'(e), SEL_W'(0), {16'(ROWS-1-e), 48'(rand64())}, 1'($urandom));
    for (int w = 1; w < WORDS; w++)
      send_item(CMD_KEY, IDX_W'(e), SEL_W'(w), rand64(), 1'($urandom));
    send_item(CMD_CNT, IDX_W'(e), SEL_W'($urandom), rand64(), 1'($urandom));
    wrote[e] = 1'b1;
  endtask

  // Write every entry a full-depth search for k will probe
  task automatic fill_path(key_t k);
    int lo, hi, mid;
    key_t rk;
    lo = 0;
    hi = ROWS;
    while (hi > lo) begin
      mid = (lo + hi) / 2;
      if (!wrote.exists(mid)) write_tagged(mid);
      rk = sb.row_key(mid);
      if (rk == k || mid <= lo) break;
      if (rk > k) lo = mid;
      else hi = mid;
    end
  endtask

  task automatic deep_query(key_t k);
    fill_path(k);
    send_query(k);
  endtask

  // entry_count only changes once every lookup is back and the block is quiet
  task automatic program_entry_count(bit [CFG_W-1:0] v);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (gaps_on && $urandom_range(99) < 31) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.table_size = int'(v);
    settings++;
  endtask

  initial begin
    key_t rows [$];
    key_t k, t;
    int m, n, lim, goal, phase, base, pick, i, j;

    sb = new();
    rst_ni <= 1'b0;
    start <= 1'b0;
    cmd_i <= CMD_NONE;
    entry_index_i <= '0;
    word_sel_i <= '0;
    data_i <= '0;
    last_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table out of reset, then an unused command
    send_word(SEL_W'(0), '1, 1'b1);
    send_item(CMD_NONE, '1, '1, '1, 1'b1);

    // Three rows: top key, short string, all-zero key
    rows.push_back('1);
    rows.push_back(key_t'(64'h6162_0000_0000_0000) << ((WORDS-1)*DATA_W));
    rows.push_back('0);
    load_rows(rows);
    send_item(CMD_KEY, IDX_W'(1), SEL_UNUSED, '1, 1'b0);
    program_entry_count(CFG_W'(3));
    send_query(rows[0]);
    send_query(rows[1]);
    send_word(SEL_UNUSED, rand64(), 1'b1);
    send_query(rows[1] - 1);
    // single row: only the last compare decides
    program_entry_count(CFG_W'(1));
    send_query(rows[0]);
    send_query(rows[1]);
    program_entry_count(CFG_W'(2));
    send_query(rows[1]);

    // Full-depth table, written only where the searches below probe
    gaps_on = 1'b0;
    write_tagged(0);
    write_tagged(ROWS-1);
    fill_path(sb.row_key(0));
    fill_path(sb.row_key(ROWS-1));
    gaps_on = 1'b1;
    program_entry_count(CFG_W'(ROWS));
    deep_query(sb.row_key(0));
    deep_query(sb.row_key(ROWS-1));
    deep_query('1);
    deep_query('0);
    deep_query(sb.row_key(ROWS/2));
    deep_query(sb.row_key(ROWS-1) + 1);
    // oversized counts saturate to the table depth
    program_entry_count('1);
    deep_query(sb.row_key(ROWS-1));
    program_entry_count(CFG_W'(ROWS+1));
    deep_query(sb.row_key(ROWS/4));

    // Random phases: fresh sorted small table, then mostly real lookups
    base = items;
    phase = 0;
    while (items - base < 360) begin
      gaps_on = (phase != 1);
      rows.delete();
      m = $urandom_range(12, 1);
      for (i = 0; i < m; i++) rows.push_back(random_key());
      for (i = 1; i < m; i++) begin
        t = rows[i];
        j = i - 1;
        while (j >= 0 && rows[j] < t) begin
          rows[j+1] = rows[j];
          j--;
        end
        rows[j+1] = t;
      end
      load_rows(rows);
      case ($urandom_range(9))
        0: n = 0;
        1: n = $urandom_range(m - 1, 0);
        2: n = $urandom_range(filled, m);
        default: n = m;
      endcase
      program_entry_count(CFG_W'(n));
      lim = (n > m) ? n : m;
      goal = items + $urandom_range(40, 20);
      while (items < goal) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          send_query(rows[$urandom_range(m - 1)]);
        end else if (pick < 65) begin
          // near miss around a stored key
          k = rows[$urandom_range(m - 1)];
          case ($urandom_range(2))
            0: k[$urandom_range(WORDS*DATA_W - 1)] ^= 1'b1;
            1: k = k + 1;
            default: k = k - 1;
          endcase
          send_query(k);
        end else if (pick < 72) begin
          send_query(random_key());
        end else if (pick < 77) begin
          for (i = 0; i < WORDS; i++) k[i*DATA_W +: DATA_W] = rand64();
          send_query(k);
        end else if (pick < 82) begin
          send_query($urandom_range(1) ? key_t'('1) : key_t'('0));
        end else if (pick < 87) begin
          // abandoned query, leftovers carry into the next one
          repeat ($urandom_range(3, 1)) send_word(SEL_W'($urandom), rand64(), 1'b0);
        end else begin
          case ($urandom_range(3))
            0: send_item(CMD_NONE, IDX_W'($urandom), SEL_W'($urandom), rand64(), 1'($urandom));
            1: send_item(CMD_CNT, IDX_W'($urandom), SEL_W'($urandom), rand64(), 1'($urandom));
            2: send_item(CMD_KEY, IDX_W'($urandom), SEL_UNUSED, rand64(), 1'($urandom));
            default: begin
              if (lim < ROWS)
                send_item(CMD_KEY, IDX_W'($urandom_range(ROWS - 1, lim)),
                          SEL_W'($urandom_range(WORDS - 1)), rand64(), 1'($urandom));
            end
          endcase
        end
      end
      phase++;
    end

    // entry_count written back to zero
    program_entry_count('0);
    send_query(rows[0]);

    start <= 1'b0;
    for (i = 0; i < 5000 && sb.pending.size() != 0; i++) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.pending.size() != 0) $error("%0d lookups never answered", sb.pending.size());

    $display("Checked %0d lookups (%0d hits) over %0d entry_count settings.",
             sb.checked, sb.hits, settings);
    $display("Sent %0d words (%0d query words) over a full-depth table and %0d small tables.",
             items, query_words, phase);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS sorted_string_table_search");
    end else begin
      $display("FAIL sorted_string_table_search");
    end
    $finish;
  end

endmodule
